### rtl/core/mrm_pkg.sv
// shared types and constants for the rendezvous matcher
`timescale 1ns / 1ps
package mrm_pkg;
	localparam int SLOTS_DEF = 256;
	localparam int PIDS_DEF = 64;
	localparam int HANDLE_BITS_DEF = 32;
	localparam int PID_W = 6;

	typedef enum logic [1:0] {
		ACT_SEND = 2'd0,
		ACT_RECV = 2'd1,
		ACT_IRQ  = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_FREE = 2'd0,
		KIND_SEND = 2'd1,
		KIND_RECV = 2'd2,
		KIND_RSVD = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		OUT_MATCHED   = 3'd0,
		OUT_QUEUED    = 3'd1,
		OUT_FULL      = 3'd2,
		OUT_IRQ_DELIV = 3'd3,
		OUT_IRQ_LATCH = 3'd4
	} outcome_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_UNLINK,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_APPEND,
		ST_OUT
	} state_t;
endpackage

### rtl/core/message_rendezvous_matcher.sv
// top level of the rendezvous matcher: sequencer over the slot tables
// throughput: one request in flight; the next is accepted in the idle cycle after the result
// reset: a clearing pass marks every slot free before requests are taken
// the output register holds a finished result while the next request runs
`timescale 1ns / 1ps
module message_rendezvous_matcher #(
	parameter int SLOTS = mrm_pkg::SLOTS_DEF,
	parameter int PIDS = mrm_pkg::PIDS_DEF,
	parameter int HANDLE_BITS = mrm_pkg::HANDLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                action,
	input  logic [mrm_pkg::PID_W-1:0] own_pid,
	input  logic [mrm_pkg::PID_W-1:0] peer_pid,
	input  logic [HANDLE_BITS-1:0]    msg_handle,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                outcome,
	output logic                      wake_valid,
	output logic [mrm_pkg::PID_W-1:0] wake_pid,
	output logic [HANDLE_BITS-1:0]    dest_handle,
	output logic [HANDLE_BITS-1:0]    src_handle,
	output logic [mrm_pkg::PID_W-1:0] sender_pid
);
	import mrm_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int LW = AW + 1;
	localparam int EW = 2 + 2 * PID_W + HANDLE_BITS;
	localparam logic [LW-1:0] NIL = LW'(SLOTS);

	state_t state_q, state_d;

	// entry ram: kind, from, to, handle ; link ram separate
	logic          e_we;
	logic [AW-1:0] e_wa, e_ra;
	logic [EW-1:0] e_wd, e_rd;
	logic          l_we;
	logic [AW-1:0] l_wa, l_ra;
	logic [LW-1:0] l_wd, l_rd;

	mrm_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_entry (
		.clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd)
	);
	mrm_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link (
		.clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd)
	);

	kind_t                  rd_kind;
	logic [PID_W-1:0]       rd_from, rd_to;
	logic [HANDLE_BITS-1:0] rd_handle;
	assign rd_kind   = kind_t'(e_rd[EW-1 -: 2]);
	assign rd_from   = e_rd[EW-3 -: PID_W];
	assign rd_to     = e_rd[EW-3-PID_W -: PID_W];
	assign rd_handle = e_rd[HANDLE_BITS-1:0];

	// request registers
	action_t                act_q;
	logic [PID_W-1:0]       own_q, peer_q;
	logic [HANDLE_BITS-1:0] h_q;
	logic [LW-1:0]          first_q, cur_q, prev_q, last_q;
	logic [AW:0]            cnt_q;
	logic [PIDS-1:0]        irq_q;

	// working result
	outcome_t               r_oc_q;
	logic                   r_wv_q;
	logic [PID_W-1:0]       r_wp_q, r_sp_q;
	logic [HANDLE_BITS-1:0] r_dh_q, r_sh_q;

	// output register
	logic                   ovalid_q;
	outcome_t               oc_q;
	logic                   wv_q;
	logic [PID_W-1:0]       wp_q, sp_q;
	logic [HANDLE_BITS-1:0] dh_q, sh_q;

	kind_t            want_kind;
	logic [PID_W-1:0] want_pid;
	logic             hit, out_free, in_acc;

	assign out_free = !ovalid_q || !out_stall;
	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		want_kind = KIND_RECV;
		want_pid = peer_q;
		unique case (act_q)
			ACT_SEND: begin
				want_kind = KIND_RECV;
				want_pid = peer_q;
			end
			ACT_RECV: begin
				want_kind = KIND_SEND;
				want_pid = own_q;
			end
			default: begin
				want_kind = KIND_RECV;
				want_pid = own_q;
			end
		endcase
	end
	assign hit = (rd_kind == want_kind) && (rd_to == want_pid);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (cnt_q == (AW+1)'(SLOTS - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_acc && action != ACT_NONE) begin
					if (first_q != NIL) begin
						state_d = ST_WALK_RD;
					end else begin
						state_d = (action == ACT_IRQ) ? ST_OUT : ST_FREE_RD;
					end
				end
			end
			ST_WALK_RD: state_d = ST_WALK_CHK;
			ST_WALK_CHK: begin
				if (hit) begin
					state_d = ST_UNLINK;
				end else if (l_rd == NIL) begin
					state_d = (act_q == ACT_IRQ) ? ST_OUT : ST_FREE_RD;
				end else begin
					state_d = ST_WALK_RD;
				end
			end
			ST_UNLINK: state_d = ST_OUT;
			ST_FREE_RD: state_d = ST_FREE_CHK;
			ST_FREE_CHK: begin
				if (rd_kind == KIND_FREE) begin
					state_d = ST_APPEND;
				end else if (cnt_q == (AW+1)'(SLOTS - 1)) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_FREE_RD;
				end
			end
			ST_APPEND: state_d = ST_OUT;
			ST_OUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		e_we = 1'b0;
		e_wa = cur_q[AW-1:0];
		e_wd = '0;
		e_ra = cur_q[AW-1:0];
		l_we = 1'b0;
		l_wa = prev_q[AW-1:0];
		l_wd = NIL;
		l_ra = cur_q[AW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				e_we = 1'b1;
				e_wa = cnt_q[AW-1:0];
				e_wd = {KIND_FREE, {(EW-2){1'b0}}};
			end
			ST_FREE_RD: begin
				e_ra = cnt_q[AW-1:0];
			end
			ST_FREE_CHK: begin
				// a free slot about to be taken gets its end of list link now
				l_we = (rd_kind == KIND_FREE);
				l_wa = cnt_q[AW-1:0];
				l_wd = NIL;
			end
			ST_UNLINK: begin
				e_we = 1'b1;
				e_wa = cur_q[AW-1:0];
				e_wd = {KIND_FREE, rd_from, rd_to, rd_handle};
				l_we = (prev_q != NIL);
				l_wa = prev_q[AW-1:0];
				l_wd = l_rd;
			end
			ST_APPEND: begin
				e_we = 1'b1;
				e_wa = cnt_q[AW-1:0];
				e_wd = (act_q == ACT_SEND)
					? {KIND_SEND, own_q, peer_q, h_q}
					: {KIND_RECV, peer_q, own_q, h_q};
				l_we = (first_q != NIL);
				l_wa = last_q[AW-1:0];
				l_wd = cnt_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			first_q <= NIL;
			irq_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && out_free) ovalid_q <= 1'b1;
			else if (!out_stall) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: cnt_q <= cnt_q + (AW+1)'(1);
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_acc && action == ACT_IRQ && first_q == NIL && int'(own_pid) < PIDS) begin
						irq_q[own_pid] <= 1'b1;
					end
				end
				ST_WALK_CHK: begin
					if (!hit && l_rd == NIL && act_q == ACT_IRQ && int'(own_q) < PIDS) begin
						irq_q[own_q] <= 1'b1;
					end
				end
				ST_UNLINK: if (prev_q == NIL) first_q <= l_rd;
				ST_FREE_CHK: if (rd_kind != KIND_FREE) cnt_q <= cnt_q + (AW+1)'(1);
				ST_APPEND: if (first_q == NIL) first_q <= cnt_q;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			act_q <= action_t'(action);
			own_q <= own_pid;
			peer_q <= peer_pid;
			h_q <= msg_handle;
			cur_q <= first_q;
			prev_q <= NIL;
			r_oc_q <= OUT_IRQ_LATCH;
			r_wv_q <= 1'b0;
			r_wp_q <= '0;
			r_dh_q <= '0;
			r_sh_q <= '0;
			r_sp_q <= '0;
		end else if (state_q == ST_WALK_CHK) begin
			if (hit) begin
				r_wv_q <= 1'b1;
				unique case (act_q)
					ACT_SEND: begin
						r_oc_q <= OUT_MATCHED;
						r_wp_q <= peer_q;
						r_dh_q <= rd_handle;
						r_sh_q <= h_q;
						r_sp_q <= own_q;
					end
					ACT_RECV: begin
						r_oc_q <= OUT_MATCHED;
						r_wp_q <= rd_from;
						r_dh_q <= h_q;
						r_sh_q <= rd_handle;
						r_sp_q <= rd_from;
					end
					default: begin
						r_oc_q <= OUT_IRQ_DELIV;
						r_wp_q <= own_q;
						r_dh_q <= rd_handle;
					end
				endcase
			end else begin
				prev_q <= cur_q;
				cur_q <= l_rd;
				last_q <= cur_q;
			end
		end else if (state_q == ST_FREE_RD) begin
			r_oc_q <= OUT_FULL;
		end else if (state_q == ST_APPEND) begin
			r_oc_q <= OUT_QUEUED;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			oc_q <= r_oc_q;
			wv_q <= r_wv_q;
			wp_q <= r_wp_q;
			dh_q <= r_dh_q;
			sh_q <= r_sh_q;
			sp_q <= r_sp_q;
		end
	end

	assign out_valid   = ovalid_q;
	assign outcome     = oc_q;
	assign wake_valid  = wv_q;
	assign wake_pid    = wp_q;
	assign dest_handle = dh_q;
	assign src_handle  = sh_q;
	assign sender_pid  = sp_q;
endmodule

### rtl/core/mrm_ram.sv
// generic ram with one write port and one separate read port, registered read
`timescale 1ns / 1ps
module mrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
